>>> rtl/pngs_pkg.sv
`default_nettype none

package pngs_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int PEAK_W    = 15;
    localparam int GAIN_W    = 31;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int DIV_STEPS = GAIN_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // 0.99 full scale in Q16, divided by the peak magnitude
    localparam logic [GAIN_W-1:0] GAIN_NUMERATOR = 31'd2126008812;
    localparam logic [GAIN_W-1:0] UNITY_GAIN     = 31'd65536;

    typedef struct packed {
        logic accept;       // capture sample
        logic peak_update;  // measure item: fold magnitude into peak
        logic div_init;     // clear divider
        logic div_step;     // one quotient bit
        logic mul;          // register sample * gain
        logic load_amp;     // amplified sample into output register
        logic load_report;  // new gain into output register
    } pngs_cmd_t;

    typedef struct packed {
        logic out_free;
        logic div_done;
    } pngs_status_t;

endpackage

`default_nettype wire

>>> rtl/peak_normalizing_gain_stage.sv
`default_nettype none
// Channel  | Ports                                        | Direction
// input    | s_valid s_ready s_kind s_sample s_last       | in
// result   | m_valid m_ready m_out_sample m_gain_value    | out
//          | m_is_gain_report                             |
//
// Measure item without last: no result; the input stays ready for the next item.
// Amplify item: capture, 16x31 multiply, then saturate into output register.
// Measure item with last: the restoring divider makes one quotient
// bit per cycle for 31 bits, then the gain report is loaded.
// Reset (aresetn low, synchronous): peak 0, gain unity, output register empty.
// A result waiting on m_ready holds only the next amplify or report final load.

module peak_normalizing_gain_stage (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     s_valid,
    output logic                                    s_ready,
    input  wire                                     s_kind,
    input  wire signed [pngs_pkg::SAMPLE_W-1:0]     s_sample,
    input  wire                                     s_last,
    output logic                                    m_valid,
    input  wire                                     m_ready,
    output logic signed [pngs_pkg::SAMPLE_W-1:0]    m_out_sample,
    output logic [pngs_pkg::GAIN_W-1:0]             m_gain_value,
    output logic                                    m_is_gain_report
);

    pngs_pkg::pngs_cmd_t    cmd;
    pngs_pkg::pngs_status_t status;

    pngs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_kind),
        .s_last  (s_last),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    pngs_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_sample         (s_sample),
        .cmd              (cmd),
        .status           (status),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_out_sample     (m_out_sample),
        .m_gain_value     (m_gain_value),
        .m_is_gain_report (m_is_gain_report)
    );

    // gain report carries a zero sample
    a_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_gain_report) |-> (m_out_sample == '0))
        else $error("gain report with nonzero sample");

    // reported gain is never zero: the peak is at most 32767
    a_gain_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_gain_report) |-> (m_gain_value != '0))
        else $error("zero gain reported");

    // an amplify transfer occupies the multiplier; no transfer on the next cycle
    a_amp_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_kind) |=> !s_ready)
        else $error("input taken during amplify");

    // last measure transfer starts the divider; input stays closed
    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_kind && s_last) |=> ##1 !s_ready)
        else $error("input taken during gain division");

endmodule

`default_nettype wire

>>> rtl/pngs_ctrl.sv
`default_nettype none

module pngs_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_valid,
    input  wire                     s_kind,
    input  wire                     s_last,
    input  pngs_pkg::pngs_status_t  status,
    output logic                    s_ready,
    output pngs_pkg::pngs_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_AMP,
        ST_DIV,
        ST_REPORT
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.accept = 1'b1;
                    if (s_kind) begin
                        state_next = ST_MUL;
                    end else begin
                        cmd.peak_update = 1'b1;
                        if (s_last) begin
                            cmd.div_init = 1'b1;
                            state_next   = ST_DIV;
                        end
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_AMP;
            end
            ST_AMP: begin
                if (status.out_free) begin
                    cmd.load_amp = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT: begin
                if (status.out_free) begin
                    cmd.load_report = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        s_ready_next = (state_next == ST_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

    assign s_ready = s_ready_reg;

endmodule

`default_nettype wire

>>> rtl/pngs_dp.sv
`default_nettype none

module pngs_dp (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire signed [pngs_pkg::SAMPLE_W-1:0]     s_sample,
    input  pngs_pkg::pngs_cmd_t                     cmd,
    output pngs_pkg::pngs_status_t                  status,
    input  wire                                     m_ready,
    output logic                                    m_valid,
    output logic signed [pngs_pkg::SAMPLE_W-1:0]    m_out_sample,
    output logic [pngs_pkg::GAIN_W-1:0]             m_gain_value,
    output logic                                    m_is_gain_report
);

    logic [pngs_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic [pngs_pkg::PEAK_W-1:0]   peak_reg, peak_next;
    logic [pngs_pkg::GAIN_W-1:0]   gain_reg, gain_next;
    logic [pngs_pkg::PEAK_W-1:0]   rem_reg, rem_next;
    logic [pngs_pkg::GAIN_W-1:0]   quot_reg, quot_next;
    logic [pngs_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [pngs_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic                          neg_reg, neg_next;
    logic                          out_valid_reg, out_valid_next;
    logic [pngs_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic [pngs_pkg::GAIN_W-1:0]   out_gain_reg, out_gain_next;
    logic                          out_report_reg, out_report_next;

    logic [pngs_pkg::SAMPLE_W-1:0] in_u, in_neg;
    logic [pngs_pkg::PEAK_W-1:0]   in_mag;
    logic [pngs_pkg::SAMPLE_W-1:0] mul_mag;
    logic [pngs_pkg::CNT_W-1:0]    num_idx;
    logic [pngs_pkg::PEAK_W:0]     trial, divisor, diff;
    logic                          ge;
    logic [pngs_pkg::GAIN_W-1:0]   shifted;
    logic [pngs_pkg::SAMPLE_W-1:0] amp_val;
    logic [pngs_pkg::GAIN_W-1:0]   new_gain;
    logic                          out_free;

    always_comb begin
        // magnitude of the incoming sample; most negative code clips to 32767
        in_u   = s_sample;
        in_neg = ~in_u + 1'b1;
        if (!in_u[pngs_pkg::SAMPLE_W-1]) begin
            in_mag = in_u[pngs_pkg::PEAK_W-1:0];
        end else if (in_neg[pngs_pkg::SAMPLE_W-1]) begin
            in_mag = '1;
        end else begin
            in_mag = in_neg[pngs_pkg::PEAK_W-1:0];
        end

        mul_mag = sample_reg[pngs_pkg::SAMPLE_W-1] ? (~sample_reg + 1'b1) : sample_reg;

        // restoring divider, numerator bits MSB first
        num_idx = pngs_pkg::CNT_W'(pngs_pkg::DIV_STEPS - 1) - cnt_reg;
        trial   = {rem_reg, pngs_pkg::GAIN_NUMERATOR[num_idx]};
        divisor = {1'b0, peak_reg};
        ge      = (trial >= divisor);
        diff    = trial - divisor;

        shifted = prod_reg[pngs_pkg::PROD_W-1:16];
        if (neg_reg) begin
            if (shifted > pngs_pkg::GAIN_W'(32768)) begin
                amp_val = 16'h8000;
            end else begin
                amp_val = ~shifted[pngs_pkg::SAMPLE_W-1:0] + 1'b1;
            end
        end else begin
            if (shifted > pngs_pkg::GAIN_W'(32767)) begin
                amp_val = 16'h7fff;
            end else begin
                amp_val = shifted[pngs_pkg::SAMPLE_W-1:0];
            end
        end

        new_gain = (peak_reg == '0) ? pngs_pkg::UNITY_GAIN : quot_reg;
        out_free = !out_valid_reg || m_ready;

        sample_next     = sample_reg;
        peak_next       = peak_reg;
        gain_next       = gain_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        out_sample_next = out_sample_reg;
        out_gain_next   = out_gain_reg;
        out_report_next = out_report_reg;
        out_valid_next  = out_valid_reg && !m_ready;

        if (cmd.accept) begin
            sample_next = s_sample;
        end
        if (cmd.peak_update && (in_mag > peak_reg)) begin
            peak_next = in_mag;
        end
        if (cmd.div_init) begin
            rem_next  = '0;
            quot_next = '0;
            cnt_next  = '0;
        end
        if (cmd.div_step) begin
            rem_next  = ge ? diff[pngs_pkg::PEAK_W-1:0] : trial[pngs_pkg::PEAK_W-1:0];
            quot_next = {quot_reg[pngs_pkg::GAIN_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
        end
        if (cmd.mul) begin
            prod_next = pngs_pkg::PROD_W'(mul_mag) * pngs_pkg::PROD_W'(gain_reg);
            neg_next  = sample_reg[pngs_pkg::SAMPLE_W-1];
        end
        if (cmd.load_amp) begin
            out_sample_next = amp_val;
            out_gain_next   = gain_reg;
            out_report_next = 1'b0;
            out_valid_next  = 1'b1;
        end
        if (cmd.load_report) begin
            out_sample_next = '0;
            out_gain_next   = new_gain;
            out_report_next = 1'b1;
            out_valid_next  = 1'b1;
            gain_next       = new_gain;
            peak_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg      <= '0;
            gain_reg      <= pngs_pkg::UNITY_GAIN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            peak_reg      <= peak_next;
            gain_reg      <= gain_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg     <= sample_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        out_sample_reg <= out_sample_next;
        out_gain_reg   <= out_gain_next;
        out_report_reg <= out_report_next;
    end

    assign status.out_free = out_free;
    assign status.div_done = (cnt_reg == pngs_pkg::CNT_W'(pngs_pkg::DIV_STEPS - 1));

    assign m_valid          = out_valid_reg;
    assign m_out_sample     = out_sample_reg;
    assign m_gain_value     = out_gain_reg;
    assign m_is_gain_report = out_report_reg;

endmodule

`default_nettype wire

>>> tb/pngs_gain_checker.sv
package pngs_tb_pkg;

    typedef enum logic {
        KIND_MEASURE = 1'b0,
        KIND_AMPLIFY = 1'b1
    } item_kind_t;

endpackage

module pngs_gain_checker (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    input  wire                                  s_ready,
    input  wire                                  s_kind,
    input  wire signed [pngs_pkg::SAMPLE_W-1:0]  s_sample,
    input  wire                                  s_last,
    input  wire                                  m_valid,
    input  wire                                  m_ready,
    input  wire signed [pngs_pkg::SAMPLE_W-1:0]  m_out_sample,
    input  wire [pngs_pkg::GAIN_W-1:0]           m_gain_value,
    input  wire                                  m_is_gain_report,
    output int                                   mismatch_count,
    output int                                   results_owed
);

    typedef struct {
        logic [pngs_pkg::SAMPLE_W-1:0] out_sample;
        logic [pngs_pkg::GAIN_W-1:0]   gain;
        logic                          report;
    } gain_stage_result_t;

    gain_stage_result_t            expected_results[$];
    logic [pngs_pkg::PEAK_W-1:0]   peak_track;
    logic [pngs_pkg::GAIN_W-1:0]   gain_latched;
    int                            errors = 0;

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
    end

    // -32768 has no 15-bit magnitude; it counts as 32767
    function automatic logic [pngs_pkg::PEAK_W-1:0] sample_magnitude(
        logic signed [pngs_pkg::SAMPLE_W-1:0] s
    );
        logic signed [pngs_pkg::SAMPLE_W-1:0] neg_s;
        if (s == {1'b1, {(pngs_pkg::SAMPLE_W-1){1'b0}}})
            return {pngs_pkg::PEAK_W{1'b1}};
        neg_s = -s;
        return s[pngs_pkg::SAMPLE_W-1] ? neg_s[pngs_pkg::PEAK_W-1:0]
                                       : s[pngs_pkg::PEAK_W-1:0];
    endfunction

    function automatic logic [pngs_pkg::GAIN_W-1:0] gain_for_peak(
        logic [pngs_pkg::PEAK_W-1:0] peak
    );
        if (peak == '0)
            return pngs_pkg::UNITY_GAIN;
        return pngs_pkg::GAIN_NUMERATOR / pngs_pkg::GAIN_W'(peak);
    endfunction

    // sign-magnitude multiply, shift truncates toward zero, then saturate
    function automatic logic [pngs_pkg::SAMPLE_W-1:0] scale_sample(
        logic signed [pngs_pkg::SAMPLE_W-1:0] s,
        logic [pngs_pkg::GAIN_W-1:0] gain
    );
        logic [pngs_pkg::SAMPLE_W-1:0] mag;
        logic [pngs_pkg::PROD_W-1:0]   prod;
        logic [pngs_pkg::GAIN_W-1:0]   scaled;
        logic [pngs_pkg::SAMPLE_W-1:0] neg_scaled;
        mag    = s[pngs_pkg::SAMPLE_W-1] ? (~s + 1'b1) : s;
        prod   = pngs_pkg::PROD_W'(mag) * pngs_pkg::PROD_W'(gain);
        scaled = prod[pngs_pkg::PROD_W-1:16];
        if (s[pngs_pkg::SAMPLE_W-1]) begin
            if (scaled > 32768)
                return {1'b1, {(pngs_pkg::SAMPLE_W-1){1'b0}}};
            neg_scaled = ~scaled[pngs_pkg::SAMPLE_W-1:0] + 1'b1;
            return neg_scaled;
        end
        if (scaled > 32767)
            return {1'b0, {(pngs_pkg::SAMPLE_W-1){1'b1}}};
        return scaled[pngs_pkg::SAMPLE_W-1:0];
    endfunction

    always @(posedge aclk) begin
        gain_stage_result_t          want;
        logic [pngs_pkg::PEAK_W-1:0] mag;
        if (!aresetn) begin
            expected_results.delete();
            peak_track   = '0;
            gain_latched = pngs_pkg::UNITY_GAIN;
        end else begin
            // a result can never come from the input taken at the same edge
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer: out %0d gain %0d report %0b",
                                 m_out_sample, m_gain_value, m_is_gain_report);
                end else begin
                    want = expected_results.pop_front();
                    if (m_out_sample !== want.out_sample || m_gain_value !== want.gain ||
                        m_is_gain_report !== want.report) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp %0d %0d %0b, got %0d %0d %0b",
                                     $signed(want.out_sample), want.gain, want.report,
                                     m_out_sample, m_gain_value, m_is_gain_report);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_kind == pngs_tb_pkg::KIND_MEASURE) begin
                    mag = sample_magnitude(s_sample);
                    if (mag > peak_track)
                        peak_track = mag;
                    if (s_last) begin
                        gain_latched = gain_for_peak(peak_track);
                        peak_track   = '0;
                        expected_results.push_back('{out_sample: '0, gain: gain_latched,
                                                     report: 1'b1});
                    end
                end else begin
                    expected_results.push_back('{out_sample: scale_sample(s_sample, gain_latched),
                                                 gain: gain_latched, report: 1'b0});
                end
            end
        end
        mismatch_count <= errors;
        results_owed   <= expected_results.size();
    end

endmodule

>>> tb/tb_peak_normalizing_gain_stage.sv
module tb_peak_normalizing_gain_stage;

    localparam int CYCLE_LIMIT = 200000;

    logic                                 aclk = 1'b0;
    logic                                 aresetn = 1'b0;
    logic                                 s_valid = 1'b0;
    logic                                 s_kind = pngs_tb_pkg::KIND_MEASURE;
    logic signed [pngs_pkg::SAMPLE_W-1:0] s_sample = '0;
    logic                                 s_last = 1'b0;
    logic                                 m_ready = 1'b0;
    logic                                 s_ready;
    logic                                 m_valid;
    logic signed [pngs_pkg::SAMPLE_W-1:0] m_out_sample;
    logic [pngs_pkg::GAIN_W-1:0]          m_gain_value;
    logic                                 m_is_gain_report;

    int mismatch_count;
    int results_owed;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    int idle_plan[4] = '{0, 74, 0, 24};
    int stall_plan[4] = '{0, 0, 74, 24};

    always #2 aclk = ~aclk;

    peak_normalizing_gain_stage i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_sample         (s_sample),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_sample     (m_out_sample),
        .m_gain_value     (m_gain_value),
        .m_is_gain_report (m_is_gain_report)
    );

    pngs_gain_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_sample         (s_sample),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_sample     (m_out_sample),
        .m_gain_value     (m_gain_value),
        .m_is_gain_report (m_is_gain_report),
        .mismatch_count   (mismatch_count),
        .results_owed     (results_owed)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("peak_normalizing_gain_stage regression: fail");
            $finish;
        end
    end

    // valid stays up across back-to-back transfers; it drops only for idle cycles
    task automatic send_item(logic kind, logic signed [pngs_pkg::SAMPLE_W-1:0] sample,
                             logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_kind   <= kind;
        s_sample <= sample;
        s_last   <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // narrow magnitudes give large gains and exercise saturation
    function automatic logic signed [pngs_pkg::SAMPLE_W-1:0] random_sample(int bits);
        logic signed [pngs_pkg::SAMPLE_W-1:0] mag;
        if (bits >= pngs_pkg::SAMPLE_W)
            return pngs_pkg::SAMPLE_W'($urandom);
        mag = pngs_pkg::SAMPLE_W'($urandom_range(0, (1 << bits) - 1));
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic random_traffic(int count);
        int sent;
        int len;
        int bits;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 80) begin
                len  = $urandom_range(1, 8);
                bits = $urandom_range(1, 16);
                for (int i = 0; i < len; i++)
                    send_item(pngs_tb_pkg::KIND_MEASURE, random_sample(bits), i == len - 1);
                sent += len;
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    send_item(pngs_tb_pkg::KIND_AMPLIFY, random_sample(16),
                              1'($urandom_range(0, 1)));
                sent += len;
            end else begin
                send_item(1'($urandom_range(0, 1)), random_sample(16),
                          1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // unity gain straight out of reset, last ignored on amplify
        send_item(pngs_tb_pkg::KIND_AMPLIFY, 16'sd32767, 1'b0);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, -16'sd32768, 1'b0);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, 16'sd0, 1'b1);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, -16'sd1, 1'b0);
        // zero peak gives unity gain
        send_item(pngs_tb_pkg::KIND_MEASURE, 16'sd0, 1'b1);
        // most negative sample counts as 32767
        send_item(pngs_tb_pkg::KIND_MEASURE, 16'sd100, 1'b0);
        send_item(pngs_tb_pkg::KIND_MEASURE, -16'sd32768, 1'b0);
        send_item(pngs_tb_pkg::KIND_MEASURE, 16'sd5, 1'b1);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, 16'sd32767, 1'b0);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, -16'sd32768, 1'b0);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, 16'sd1, 1'b0);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, -16'sd1, 1'b0);
        // peak of one gives the largest gain; saturation both ways
        send_item(pngs_tb_pkg::KIND_MEASURE, 16'sd1, 1'b1);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, 16'sd1, 1'b0);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, -16'sd1, 1'b0);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, 16'sd2, 1'b0);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, -16'sd2, 1'b0);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, 16'sd32767, 1'b1);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, -16'sd32768, 1'b0);
        send_item(pngs_tb_pkg::KIND_MEASURE, -16'sd1, 1'b0);
        send_item(pngs_tb_pkg::KIND_MEASURE, 16'sd32767, 1'b1);
        send_item(pngs_tb_pkg::KIND_AMPLIFY, -16'sd12345, 1'b0);

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_plan[p];
            stall_pct     = stall_plan[p];
            random_traffic(100);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatch_count == 0)
            $display("peak_normalizing_gain_stage regression: pass");
        else
            $display("peak_normalizing_gain_stage regression: fail");
        $finish;
    end

endmodule
